// ===== rtl/core/pad_frame_keyboard_tracker_macros.svh =====
// Assertion macros for the pad frame keyboard tracker.
// Depends on nothing; included by the top level only.
`ifndef PAD_FRAME_KEYBOARD_TRACKER_MACROS_SVH
`define PAD_FRAME_KEYBOARD_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define PFT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pft: implication check failed");
`define PFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pft: next-cycle check failed");
`else
`define PFT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/pft_pkg.sv =====
// Package for the pad frame keyboard tracker: payload structs, event types, constants.
// Depends on nothing; used by every module of the block.
package pft_pkg;

    localparam int KEY_BYTES_DEF = 18;
    localparam int KEY_BYTES_MAX = 18;
    localparam int PAD_BITS      = KEY_BYTES_MAX * 8;
    localparam int FRAME_W       = 56;
    localparam int SEG_W         = 48;

    localparam logic [3:0] IDLE_COUNT     = 4'd15;
    localparam logic [3:0] HEADER_NIBBLES = 4'd6;
    localparam logic [3:0] LAST_POS       = 4'd14;
    localparam logic [3:0] LEN_PAD3D      = 4'd14;
    localparam logic [3:0] LEN_KEYBOARD   = 4'd10;
    localparam logic [3:0] LEN_MOUSE      = 4'd8;
    localparam logic [31:0] NONE_FILL     = 32'h8080_0000;
    localparam logic [7:0] HIGH_BIT       = 8'h80;
    localparam logic [7:0] LOST_BIT_LIMIT = 8'd16;

    typedef struct packed {
        logic       frame_start;
        logic [3:0] nibble;
    } pft_in_t;

    typedef struct packed {
        logic               is_keyboard;
        logic [FRAME_W-1:0] frame_bits;
        logic               key_make;
        logic               key_break;
        logic [7:0]         key_code;
        logic [SEG_W-1:0]   bitmap_segment;
        logic [1:0]         segment_index;
        logic               last;
    } pft_out_t;

    typedef struct packed {
        logic               complete;
        logic               is_kb;
        logic [FRAME_W-1:0] frame;
    } pft_evt_t;

    typedef struct packed {
        logic       mk;
        logic       bk;
        logic [7:0] code;
    } pft_key_t;

endpackage

// ===== rtl/core/pft_capture.sv =====
// Frame capture: nibble store, position counter, header decode, completion detect.
// Depends on pft_pkg.
module pft_capture
    import pft_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  pft_in_t  din,
    output logic     may_complete,
    output pft_evt_t evt
);

    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [3:0]         count_reg, count_next;
    logic [3:0]         len_reg, len_next;
    logic               hdr_reg, hdr_next;

    logic [3:0]         count_eff, len_eff, cnt1;
    logic               hdr_eff;
    logic [FRAME_W-1:0] frame_w;
    logic [3:0]         n0;
    logic [3:0]         count_p1;

    assign count_p1 = 4'(count_reg + 4'd1);

    always_comb
    begin
        may_complete = (count_reg < LAST_POS) &&
                       (((count_reg == 4'd5) && !frame_reg[52]) ||
                        ((count_p1 > HEADER_NIBBLES) && (count_p1 >= len_reg)));
    end

    always_comb
    begin
        count_eff  = din.frame_start ? 4'd0 : count_reg;
        len_eff    = din.frame_start ? HEADER_NIBBLES : len_reg;
        hdr_eff    = din.frame_start ? 1'b0 : hdr_reg;
        frame_w    = frame_reg;
        for (int i = 0; i < 14; i++)
        begin
            if (count_eff == 4'(i))
                frame_w[52 - 4 * i +: 4] = din.nibble;
        end
        cnt1       = 4'(count_eff + 4'd1);
        n0         = frame_w[55:52];
        frame_next = frame_reg;
        count_next = count_eff;
        len_next   = len_eff;
        hdr_next   = hdr_eff;
        evt        = '0;
        evt.frame  = frame_w;
        if (count_eff < LAST_POS)
        begin
            frame_next = frame_w;
            count_next = cnt1;
            if (cnt1 == HEADER_NIBBLES)
            begin
                hdr_next = 1'b0;
                priority if (!n0[0])
                begin
                    frame_next[31:0] = NONE_FILL;
                    evt.frame[31:0]  = NONE_FILL;
                    count_next       = IDLE_COUNT;
                    evt.complete     = 1'b1;
                end
                else if (!n0[1])
                    len_next = LEN_PAD3D;
                else if (!frame_w[51])
                begin
                    hdr_next = 1'b1;
                    len_next = LEN_KEYBOARD;
                end
                else
                    len_next = LEN_MOUSE;
            end
            else if ((cnt1 > HEADER_NIBBLES) && (cnt1 >= len_eff))
            begin
                count_next   = IDLE_COUNT;
                evt.complete = 1'b1;
                evt.is_kb    = hdr_eff && (frame_w[34:32] == 3'd0);
            end
        end
        evt.complete = evt.complete && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            count_reg <= IDLE_COUNT;
            len_reg   <= HEADER_NIBBLES;
            hdr_reg   <= 1'b0;
        end
        else if (accept)
        begin
            frame_reg <= frame_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            hdr_reg   <= hdr_next;
        end
    end

endmodule

// ===== rtl/core/pft_keymap.sv =====
// Key bitmap: keycode decode with lost bit seven repair, bitmap update, segment read.
// Depends on pft_pkg.
module pft_keymap
    import pft_pkg::*;
#(
    parameter int KEY_BYTES = KEY_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               upd,
    input  logic [FRAME_W-1:0] frame,
    input  logic [1:0]         seg_sel,
    output pft_key_t           key,
    output logic [SEG_W-1:0]   segment
);

    localparam int KEY_BITS = KEY_BYTES * 8;

    logic [KEY_BITS-1:0] bitmap_reg, bitmap_next;
    logic [PAD_BITS-1:0] padded;
    logic [7:0]          raw_code, hi_code;
    logic                down_lo, down_hi, clr_hi;

    always_comb
    begin
        raw_code = frame[23:16];
        hi_code  = raw_code | HIGH_BIT;
        key.mk   = frame[27];
        key.bk   = frame[24];
        down_lo  = 1'b0;
        down_hi  = 1'b0;
        for (int i = 0; i < KEY_BITS; i++)
        begin
            if (raw_code == 8'(i))
                down_lo = bitmap_reg[i];
            if (hi_code == 8'(i))
                down_hi = bitmap_reg[i];
        end
        key.code = raw_code;
        clr_hi   = 1'b0;
        if (key.bk && (raw_code < LOST_BIT_LIMIT))
        begin
            priority if (!down_lo)
                key.code = hi_code;
            else if (down_hi)
                clr_hi = 1'b1;
            else
                clr_hi = 1'b0;
        end
        bitmap_next = bitmap_reg;
        for (int i = 0; i < KEY_BITS; i++)
        begin
            if (clr_hi && (hi_code == 8'(i)))
                bitmap_next[i] = 1'b0;
            if (key.mk && (key.code == 8'(i)))
                bitmap_next[i] = 1'b1;
            if (key.bk && (key.code == 8'(i)))
                bitmap_next[i] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bitmap_reg <= '0;
        else if (upd)
            bitmap_reg <= bitmap_next;
    end

    assign padded = PAD_BITS'(bitmap_reg);

    always_comb
    begin
        unique case (seg_sel)
            2'd0:    segment = padded[SEG_W-1:0];
            2'd1:    segment = padded[2*SEG_W-1:SEG_W];
            2'd2:    segment = padded[3*SEG_W-1:2*SEG_W];
            default: segment = '0;
        endcase
    end

endmodule

// ===== rtl/core/pad_frame_keyboard_tracker.sv =====
// Pad frame keyboard tracker: top level with the result register and segment sequencer.
// Depends on pft_pkg, pft_capture, pft_keymap and pad_frame_keyboard_tracker_macros.svh.
//
// Input channel nib_valid/nib_ready/nib_data carries one handshake nibble per transaction,
// with frame_start marking the first nibble of a frame. Output channel
// res_valid/res_ready/res_data carries the decoded results.
// A frame that completes gives its first result in the cycle after the completing nibble is taken.
// Pad, mouse and header-only frames give one result; keyboard frames give
// (KEY_BYTES+5)/6 results, at most 3, one bitmap segment each, with last on the final one.
// One nibble is taken per cycle unless a completing nibble is held back. The result
// register holds one frame's results; a completing nibble waits only while earlier
// results are still pending. A stalled receiver holds res_data; nibbles short of a
// completing position keep being taken meanwhile. Reset clears the frame store, the key
// bitmap and all pending results, and leaves capture idle until a nibble with
// frame_start arrives.
`include "pad_frame_keyboard_tracker_macros.svh"
module pad_frame_keyboard_tracker
    import pft_pkg::*;
#(
    parameter int KEY_BYTES = KEY_BYTES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     nib_valid,
    output logic     nib_ready,
    input  pft_in_t  nib_data,
    output logic     res_valid,
    input  logic     res_ready,
    output pft_out_t res_data
);

    localparam int NSEG_RAW = (KEY_BYTES + 5) / 6;
    localparam int NSEG     = (NSEG_RAW > 3) ? 3 : NSEG_RAW;
    localparam logic [1:0] SEG_LAST = 2'(NSEG - 1);

    pft_evt_t           evt;
    pft_key_t           key;
    logic [SEG_W-1:0]   segment;
    logic               may_complete, accept, load, out_last, job_free;
    logic               seg_step;
    logic [1:0]         seg_inc;

    logic               job_valid_reg, job_valid_next;
    logic [1:0]         job_seg_reg, job_seg_next;
    logic               job_kb_reg;
    logic [FRAME_W-1:0] job_frame_reg;
    pft_key_t           job_key_reg;

    assign accept = nib_valid && nib_ready;
    assign load   = accept && evt.complete;

    pft_capture u_capture
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .din          (nib_data),
        .may_complete (may_complete),
        .evt          (evt)
    );

    pft_keymap #(
        .KEY_BYTES (KEY_BYTES)
    ) u_keymap
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .upd     (load && evt.is_kb),
        .frame   (evt.frame),
        .seg_sel (job_seg_reg),
        .key     (key),
        .segment (segment)
    );

    assign out_last  = !job_kb_reg || (job_seg_reg == SEG_LAST);
    assign job_free  = !job_valid_reg || (res_ready && out_last);
    assign nib_ready = !may_complete || job_free;
    assign seg_inc   = 2'(job_seg_reg + 2'd1);
    assign seg_step  = job_valid_reg && res_ready && !out_last && !load;

    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_seg_next   = job_seg_reg;
        priority if (load)
        begin
            job_valid_next = 1'b1;
            job_seg_next   = 2'd0;
        end
        else if (job_valid_reg && res_ready)
        begin
            if (out_last)
                job_valid_next = 1'b0;
            else
                job_seg_next = seg_inc;
        end
        else
            job_valid_next = job_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_seg_reg   <= 2'd0;
            job_kb_reg    <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            job_seg_reg   <= job_seg_next;
            if (load)
                job_kb_reg <= evt.is_kb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_frame_reg <= evt.frame;
            job_key_reg   <= key;
        end
    end

    always_comb
    begin
        res_valid               = job_valid_reg;
        res_data.is_keyboard    = job_kb_reg;
        res_data.frame_bits     = job_frame_reg;
        res_data.key_make       = job_kb_reg && job_key_reg.mk;
        res_data.key_break      = job_kb_reg && job_key_reg.bk;
        res_data.key_code       = job_kb_reg ? job_key_reg.code : 8'd0;
        res_data.bitmap_segment = job_kb_reg ? segment : '0;
        res_data.segment_index  = job_kb_reg ? job_seg_reg : 2'd0;
        res_data.last           = out_last;
    end

    `PFT_ASSERT_IMP(a_no_overwrite, clk, rst_n, load, (!job_valid_reg || (res_ready && out_last)))
    `PFT_ASSERT_IMP(a_single_last, clk, rst_n, (job_valid_reg && !job_kb_reg), out_last)
    `PFT_ASSERT_IMP(a_seg_range, clk, rst_n, (job_valid_reg && job_kb_reg), (job_seg_reg <= SEG_LAST))
    `PFT_ASSERT_NEXT(a_seg_advance, clk, rst_n, seg_step, job_valid_reg && job_seg_reg == $past(seg_inc))

endmodule

// ===== verif/tb_pad_frame_keyboard_tracker.sv =====
// Testbench for pad_frame_keyboard_tracker: directed frames, then random pad, mouse, keyboard,
// header-only and noise transactions, each result checked against an in-bench frame decoder.
// Depends on pft_pkg and the pad_frame_keyboard_tracker RTL.
module tb_pad_frame_keyboard_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    import pft_pkg::*;

    localparam int KB         = KEY_BYTES_DEF;
    localparam int KEY_BITS   = KB * 8;
    localparam int SEG_COUNT  = ((KB + 5) / 6 > 3) ? 3 : (KB + 5) / 6;
    localparam int RAND_ITEMS = 420;
    localparam int SETTLE     = 16;
    localparam int DIR_COUNT  = 25;

    typedef struct packed {
        logic               fs;
        logic [3:0]         nib;
        logic               typed;
        logic [FRAME_W-1:0] frame;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
        '{1'b0, 4'hF, 1'b0, 56'h0},
        '{1'b1, 4'hE, 1'b0, 56'h0},
        '{1'b0, 4'hF, 1'b0, 56'h0},
        '{1'b0, 4'hF, 1'b0, 56'h0},
        '{1'b0, 4'hF, 1'b0, 56'h0},
        '{1'b0, 4'hF, 1'b0, 56'h0},
        '{1'b0, 4'hF, 1'b1, 56'hEF_FFFF_8080_0000},
        '{1'b1, 4'h3, 1'b0, 56'h0},
        '{1'b0, 4'h0, 1'b0, 56'h0},
        '{1'b0, 4'h0, 1'b0, 56'h0},
        '{1'b0, 4'h0, 1'b0, 56'h0},
        '{1'b0, 4'h0, 1'b0, 56'h0},
        '{1'b0, 4'h0, 1'b0, 56'h0},
        '{1'b0, 4'h0, 1'b0, 56'h0},
        '{1'b0, 4'h8, 1'b0, 56'h0},
        '{1'b0, 4'h0, 1'b0, 56'h0},
        '{1'b0, 4'h5, 1'b0, 56'h0},
        '{1'b1, 4'h3, 1'b0, 56'h0},
        '{1'b0, 4'h0, 1'b0, 56'h0},
        '{1'b1, 4'h0, 1'b0, 56'h0},
        '{1'b0, 4'h0, 1'b0, 56'h0},
        '{1'b0, 4'h0, 1'b0, 56'h0},
        '{1'b0, 4'h0, 1'b0, 56'h0},
        '{1'b0, 4'h0, 1'b0, 56'h0},
        '{1'b0, 4'h0, 1'b1, 56'h00_0000_8080_0000}
    };

    logic     clk;
    logic     rst_n;
    logic     nib_valid;
    logic     nib_ready;
    pft_in_t  nib_data;
    logic     res_valid;
    logic     res_ready;
    pft_out_t res_data;

    logic [FRAME_W-1:0]  frame_img;
    logic [3:0]          nib_pos;
    logic [3:0]          frame_len;
    logic                hdr_says_kb;
    logic [KEY_BITS-1:0] key_state;

    pft_out_t frame_batch[$];
    pft_out_t expected_results[$];

    bit quiet;
    int err_count;
    int sent_items;

    pad_frame_keyboard_tracker #(
        .KEY_BYTES (KB)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .nib_valid (nib_valid),
        .nib_ready (nib_ready),
        .nib_data  (nib_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL pad_frame_keyboard_tracker");
        $finish;
    end

    function automatic int idle_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [3:0] nib_of(int pos);
        return frame_img[(13 - pos) * 4 +: 4];
    endfunction

    function automatic logic key_is_down(logic [7:0] code);
        if (int'(code) >= KEY_BITS)
            return 1'b0;
        return key_state[code];
    endfunction

    function automatic void set_key(logic [7:0] code, logic v);
        if (int'(code) < KEY_BITS)
            key_state[code] = v;
    endfunction

    function automatic void decode_frame();
        logic [3:0]       n5;
        logic [3:0]       n7;
        logic             mk;
        logic             bk;
        logic [7:0]       code;
        logic [SEG_W-1:0] seg;
        pft_out_t         r;
        int               b;
        n5 = nib_of(5);
        r  = '0;
        r.frame_bits = frame_img;
        if (!(hdr_says_kb && n5[2:0] == 3'b000))
        begin
            r.last = 1'b1;
            frame_batch.push_back(r);
            return;
        end
        n7   = nib_of(7);
        mk   = n7[3];
        bk   = n7[0];
        code = {nib_of(8), nib_of(9)};
        // recover the top bit that the keyboard drops on low break codes
        if (bk && code < LOST_BIT_LIMIT)
        begin
            if (!key_is_down(code))
                code = code | HIGH_BIT;
            else if (key_is_down(code | HIGH_BIT))
                set_key(code | HIGH_BIT, 1'b0);
        end
        if (mk)
            set_key(code, 1'b1);
        if (bk)
            set_key(code, 1'b0);
        for (int s = 0; s < SEG_COUNT; s++)
        begin
            seg = '0;
            for (int j = 0; j < 6; j++)
            begin
                b = s * 6 + j;
                if (b < KB)
                    seg[8 * j +: 8] = key_state[8 * b +: 8];
            end
            r.is_keyboard    = 1'b1;
            r.key_make       = mk;
            r.key_break      = bk;
            r.key_code       = code;
            r.bitmap_segment = seg;
            r.segment_index  = 2'(s);
            r.last           = (s == SEG_COUNT - 1);
            frame_batch.push_back(r);
        end
    endfunction

    function automatic bit step_tracker(pft_in_t item);
        int         pos;
        logic [3:0] n0;
        logic [3:0] n1;
        if (item.frame_start)
        begin
            nib_pos     = 4'd0;
            frame_len   = HEADER_NIBBLES;
            hdr_says_kb = 1'b0;
        end
        if (nib_pos >= LAST_POS)
            return 1'b0;
        pos = nib_pos;
        frame_img[(13 - pos) * 4 +: 4] = item.nibble;
        nib_pos = nib_pos + 4'd1;
        if (nib_pos == HEADER_NIBBLES)
        begin
            n0 = nib_of(0);
            n1 = nib_of(1);
            hdr_says_kb = 1'b0;
            if (!n0[0])
            begin
                frame_img[31:0] = NONE_FILL;
                nib_pos = IDLE_COUNT;
                decode_frame();
            end
            else if (!n0[1])
                frame_len = LEN_PAD3D;
            else if (!n1[3])
            begin
                hdr_says_kb = 1'b1;
                frame_len   = LEN_KEYBOARD;
            end
            else
                frame_len = LEN_MOUSE;
        end
        else if (nib_pos > HEADER_NIBBLES && nib_pos >= frame_len)
        begin
            nib_pos = IDLE_COUNT;
            decode_frame();
        end
        return 1'b1;
    endfunction

    function automatic string show(pft_out_t r);
        return $sformatf("kb=%0d frame=%014h mk=%0d bk=%0d code=%02h seg=%012h idx=%0d last=%0d",
                         r.is_keyboard, r.frame_bits, r.key_make, r.key_break, r.key_code,
                         r.bitmap_segment, r.segment_index, r.last);
    endfunction

    task automatic send_nibble(input logic fs, input logic [3:0] nib, input logic typed,
                               input logic [FRAME_W-1:0] typed_frame);
        int       gap;
        pft_in_t  item;
        pft_out_t typed_res;
        item.frame_start = fs;
        item.nibble      = nib;
        gap = idle_gap();
        if (gap > 0)
        begin
            nib_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        nib_valid <= 1'b1;
        nib_data  <= item;
        @(posedge clk);
        while (!nib_ready)
            @(posedge clk);
        frame_batch.delete();
        if (step_tracker(item))
            sent_items++;
        if (typed && frame_batch.size() == 1)
        begin
            typed_res            = '0;
            typed_res.frame_bits = typed_frame;
            typed_res.last       = 1'b1;
            frame_batch[0]       = typed_res;
        end
        foreach (frame_batch[i])
            expected_results.push_back(frame_batch[i]);
    endtask

    task automatic drain_results();
        nib_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic send_random_frame();
        logic [3:0] nibs [14];
        logic [7:0] code;
        int         len;
        int         kind;
        int         r;
        kind = $urandom_range(0, 99);
        foreach (nibs[i])
            nibs[i] = 4'($urandom_range(0, 15));
        if (kind < 15)
        begin
            // noise: stray transactions, mostly without a frame start
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                send_nibble(($urandom_range(0, 7) == 0), nibs[i], 1'b0, '0);
            return;
        end
        if (kind < 60)
        begin
            len      = LEN_KEYBOARD;
            nibs[0]  = {2'($urandom_range(0, 3)), 2'b11};
            nibs[1]  = {1'b0, 3'($urandom_range(0, 7))};
            if ($urandom_range(0, 6) != 0)
                nibs[5] = {1'($urandom_range(0, 1)), 3'b000};
            r = $urandom_range(0, 9);
            if (r < 4)
                code = 8'($urandom_range(0, 15));
            else if (r < 6)
                code = 8'($urandom_range(128, 143));
            else if (r < 9)
                code = 8'($urandom_range(0, KEY_BITS - 1));
            else
                code = 8'($urandom_range(KEY_BITS, 255));
            nibs[8] = code[7:4];
            nibs[9] = code[3:0];
        end
        else if (kind < 75)
        begin
            len     = LEN_PAD3D;
            nibs[0] = {2'($urandom_range(0, 3)), 2'b01};
        end
        else if (kind < 90)
        begin
            len     = LEN_MOUSE;
            nibs[0] = {2'($urandom_range(0, 3)), 2'b11};
            nibs[1] = {1'b1, 3'($urandom_range(0, 7))};
        end
        else
        begin
            len     = HEADER_NIBBLES;
            nibs[0] = {3'($urandom_range(0, 7)), 1'b0};
        end
        if ($urandom_range(0, 9) == 0)
            len = $urandom_range(1, len - 1);
        for (int i = 0; i < len; i++)
            send_nibble((i == 0), nibs[i], 1'b0, '0);
    endtask

    initial
    begin : result_side
        int hold;
        hold = 0;
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                res_ready <= 1'b0;
            else if (hold > 0)
            begin
                res_ready <= 1'b0;
                hold--;
            end
            else
            begin
                res_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                    hold = idle_gap();
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        pft_out_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_results.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result at %0t: %s", $time, show(res_data));
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_data.is_keyboard !== want.is_keyboard ||
                    res_data.frame_bits !== want.frame_bits ||
                    res_data.key_make !== want.key_make ||
                    res_data.key_break !== want.key_break ||
                    res_data.key_code !== want.key_code ||
                    res_data.bitmap_segment !== want.bitmap_segment ||
                    res_data.segment_index !== want.segment_index ||
                    res_data.last !== want.last)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("result mismatch at %0t", $time);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(res_data));
                    end
                end
            end
        end
    end

    initial
    begin
        bit drained_mid;
        drained_mid = 1'b0;
        quiet       = 1'b0;
        err_count   = 0;
        sent_items  = 0;
        frame_img   = '0;
        nib_pos     = IDLE_COUNT;
        frame_len   = HEADER_NIBBLES;
        hdr_says_kb = 1'b0;
        key_state   = '0;
        rst_n     <= 1'b0;
        nib_valid <= 1'b0;
        nib_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_COUNT; i++)
            send_nibble(DIR_ROWS[i].fs, DIR_ROWS[i].nib, DIR_ROWS[i].typed, DIR_ROWS[i].frame);
        drain_results();

        sent_items = 0;
        while (sent_items < RAND_ITEMS)
        begin
            quiet = (sent_items >= 160 && sent_items < 240);
            if (!drained_mid && sent_items >= 300)
            begin
                drain_results();
                drained_mid = 1'b1;
            end
            send_random_frame();
        end
        quiet = 1'b0;

        nib_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
        repeat (SETTLE) @(posedge clk);

        if (err_count == 0 && expected_results.size() == 0)
            $display("PASS pad_frame_keyboard_tracker");
        else
            $display("FAIL pad_frame_keyboard_tracker");
        $finish;
    end
endmodule

// ===== pad_frame_keyboard_tracker.f =====
+incdir+rtl/core
rtl/core/pft_pkg.sv
rtl/core/pft_capture.sv
rtl/core/pft_keymap.sv
rtl/core/pad_frame_keyboard_tracker.sv
verif/tb_pad_frame_keyboard_tracker.sv
